// ===== hdl/socket_demux_table_macros.svh =====
// ----------------------------------------------------------------------------
// socket demux table assertion macros
// shared property forms for the socket table checks
// ----------------------------------------------------------------------------
`ifndef SOCKET_DEMUX_TABLE_MACROS_SVH
`define SOCKET_DEMUX_TABLE_MACROS_SVH

// same-cycle implication
`define SDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// socket demux table package
// sizes, codes and shared types of the socket table
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int GRP_SIZE    = 8;
   localparam int GRP_IDX_W   = $clog2(GRP_SIZE);
   localparam int NUM_GROUPS  = (TABLE_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PAD_CELLS   = NUM_GROUPS * GRP_SIZE;

   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 3;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int ICMP_W     = 8;
   localparam int SLOT_IO_W  = 6;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 4;

   localparam logic [CMD_W-1:0] CMD_BIND_UDP     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BIND_ICMP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELIVER_UDP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELIVER_ICMP = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DESCRIBE     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROP  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   // one table entry, also used as the describe readout
   typedef struct packed {
      logic            valid;
      logic            icmp;
      logic [IP_W-1:0] addr;
      logic [31:0]     ports;
   } sdt_entry_type;

   // lookup key and bind data broadcast to every cell
   typedef struct packed {
      logic            icmp;
      logic [IP_W-1:0] addr;
      logic [31:0]     udp_ports;
      logic [31:0]     bind_ports;
   } sdt_key_type;

   typedef struct packed {
      logic sel;
      logic set;
      logic clr;
   } sdt_ctl_type;

   typedef struct packed {
      logic                 any_hit;
      logic [GRP_IDX_W-1:0] hit_idx;
      logic                 any_free;
      logic [GRP_IDX_W-1:0] free_idx;
      sdt_entry_type        rd;
   } sdt_grp_type;

endpackage

// ===== hdl/sdt_cell.sv =====
// ----------------------------------------------------------------------------
// socket table cell
// one table entry with its compare and its link in the group priority chain
// ----------------------------------------------------------------------------
module sdt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sdt_pkg::sdt_key_type  key,
   input  sdt_pkg::sdt_ctl_type  ctl,
   input  logic                  hit_seen_in,
   input  logic                  free_seen_in,
   input  sdt_pkg::sdt_entry_type rd_in,
   output logic                  hit_seen_out,
   output logic                  free_seen_out,
   output logic                  hit_first,
   output logic                  free_first,
   output sdt_pkg::sdt_entry_type rd_out
);
   import sdt_pkg::*;

   logic            valid_ff;
   logic            icmp_ff;
   logic [IP_W-1:0] addr_ff;
   logic [31:0]     ports_ff;

   logic            match_in, match_ff;
   logic            free_ff;
   sdt_entry_type   rd_in_c, rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.set) begin
         valid_ff <= 1'b1;
      end else if (ctl.clr) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.set) begin
         icmp_ff  <= key.icmp;
         addr_ff  <= key.addr;
         ports_ff <= key.bind_ports;
      end
   end

   // icmp entries match on address alone
   assign match_in = valid_ff && (icmp_ff == key.icmp) && (addr_ff == key.addr)
                     && (key.icmp || (ports_ff == key.udp_ports));

   always_comb begin
      rd_in_c = '0;
      if (ctl.sel && valid_ff) begin
         rd_in_c.valid = 1'b1;
         rd_in_c.icmp  = icmp_ff;
         rd_in_c.addr  = addr_ff;
         rd_in_c.ports = ports_ff;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      free_ff  <= !valid_ff;
      rd_ff    <= rd_in_c;
   end

   assign hit_first     = match_ff && !hit_seen_in;
   assign free_first    = free_ff && !free_seen_in;
   assign hit_seen_out  = hit_seen_in || match_ff;
   assign free_seen_out = free_seen_in || free_ff;
   assign rd_out        = sdt_entry_type'(rd_in | rd_ff);

endmodule

// ===== hdl/sdt_grp.sv =====
// ----------------------------------------------------------------------------
// socket table group encoder
// registers the first hit, first free cell and readout of one cell group
// ----------------------------------------------------------------------------
module sdt_grp (
   input  logic                          clock,
   input  logic [sdt_pkg::GRP_SIZE-1:0]  hit_first,
   input  logic [sdt_pkg::GRP_SIZE-1:0]  free_first,
   input  sdt_pkg::sdt_entry_type        rd_chain,
   output sdt_pkg::sdt_grp_type          grp
);
   import sdt_pkg::*;

   sdt_grp_type grp_in, grp_ff;

   // chain leaves at most one bit set, so an or-encode suffices
   always_comb begin
      grp_in          = '0;
      grp_in.any_hit  = |hit_first;
      grp_in.any_free = |free_first;
      grp_in.rd       = rd_chain;
      for (int c = 0; c < GRP_SIZE; c++) begin
         if (hit_first[c]) begin
            grp_in.hit_idx = grp_in.hit_idx | GRP_IDX_W'(c);
         end
         if (free_first[c]) begin
            grp_in.free_idx = grp_in.free_idx | GRP_IDX_W'(c);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp = grp_ff;

endmodule

// ===== hdl/socket_demux_table.sv =====
// ----------------------------------------------------------------------------
// socket demux table
// table of bound udp and icmp sockets: bind, close, deliver lookup, describe
// ----------------------------------------------------------------------------
// channel | direction | payload
// req_*   | in        | tuser command, tdata address, ports, icmp type/code, slot
// rsp_*   | out       | tuser status and protocol, tdata slot and described fields
//
// an item passes through the steps accept, compare in every cell, group encode, then
// select with write-back into the chosen cell and load of the result register
// valid bits live in the cells, so the table is empty straight after reset
// a result waiting in the output register does not block the next accept; the
// select step waits only while that register is still full
// ----------------------------------------------------------------------------
`include "socket_demux_table_macros.svh"

module socket_demux_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cmd
   input  logic [sdt_pkg::CMD_W-1:0]        req_tuser,
   // remote_ip, local_port, remote_port, icmp_kind, icmp_subcode, slot_in
   input  logic [sdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, is_icmp
   output logic [sdt_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // slot_out, out_remote_ip, out_local_port, out_remote_port,
   // out_icmp_kind, out_icmp_subcode
   output logic [sdt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sdt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_GRP  = 2'd2;
   localparam logic [1:0] S_SEL  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [IP_W-1:0]      ip_ff;
   logic [PORT_W-1:0]    lport_ff, rport_ff;
   logic [ICMP_W-1:0]    kind_ff, sub_ff;
   logic [SLOT_IO_W-1:0] slot_ff;

   logic req_fire, sel_fire;

   sdt_key_type   key;
   sdt_ctl_type   ctl        [PAD_CELLS];
   logic [PAD_CELLS-1:0] hit_first, free_first, hit_seen, free_seen;
   logic [PAD_CELLS-1:0] cell_set, cell_clr;
   sdt_entry_type rd_chain   [PAD_CELLS];
   sdt_grp_type   grp        [NUM_GROUPS];

   logic            hit_any, free_any;
   logic [SLOT_W-1:0] hit_slot, free_slot;
   sdt_entry_type   rd_all;

   logic                 bind_ok, close_ok;
   logic [STATUS_W-1:0]  res_status;
   logic [SLOT_IO_W-1:0] res_slot;
   logic                 res_icmp;
   logic [IP_W-1:0]      res_ip;
   logic [PORT_W-1:0]    res_lport, res_rport;
   logic [ICMP_W-1:0]    res_kind, res_sub;

   logic                  rsp_valid_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign sel_fire   = (state_ff == S_SEL) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CMP;
            end
         end
         S_CMP: state_in = S_GRP;
         S_GRP: state_in = S_SEL;
         S_SEL: begin
            if (sel_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tuser;
         ip_ff    <= req_tdata[31:0];
         lport_ff <= req_tdata[47:32];
         rport_ff <= req_tdata[63:48];
         kind_ff  <= req_tdata[71:64];
         sub_ff   <= req_tdata[79:72];
         slot_ff  <= req_tdata[85:80];
      end
   end

   always_comb begin
      key.icmp       = (cmd_ff == CMD_BIND_ICMP) || (cmd_ff == CMD_DELIVER_ICMP);
      key.addr       = ip_ff;
      key.udp_ports  = {lport_ff, rport_ff};
      key.bind_ports = (cmd_ff == CMD_BIND_ICMP) ? {16'd0, kind_ff, sub_ff}
                                                 : {lport_ff, rport_ff};
   end

   // cell row, chained within each group of cells
   for (genvar i = 0; i < PAD_CELLS; i++) begin : g_cell
      logic          hit_seen_in, free_seen_in;
      sdt_entry_type rd_in;

      if (i % GRP_SIZE == 0) begin : g_head
         assign hit_seen_in  = 1'b0;
         assign free_seen_in = 1'b0;
         assign rd_in        = '0;
      end else begin : g_link
         assign hit_seen_in  = hit_seen[i-1];
         assign free_seen_in = free_seen[i-1];
         assign rd_in        = rd_chain[i-1];
      end

      assign cell_set[i] = sel_fire && bind_ok && (int'(free_slot) == i);
      assign cell_clr[i] = sel_fire && close_ok && (int'(slot_ff) == i);
      assign ctl[i].sel  = (int'(slot_ff) == i);
      assign ctl[i].set  = cell_set[i];
      assign ctl[i].clr  = cell_clr[i];

      if (i < TABLE_SLOTS) begin : g_real
         sdt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .key           (key),
            .ctl           (ctl[i]),
            .hit_seen_in   (hit_seen_in),
            .free_seen_in  (free_seen_in),
            .rd_in         (rd_in),
            .hit_seen_out  (hit_seen[i]),
            .free_seen_out (free_seen[i]),
            .hit_first     (hit_first[i]),
            .free_first    (free_first[i]),
            .rd_out        (rd_chain[i])
         );
      end else begin : g_pad
         assign hit_seen[i]   = hit_seen_in;
         assign free_seen[i]  = free_seen_in;
         assign hit_first[i]  = 1'b0;
         assign free_first[i] = 1'b0;
         assign rd_chain[i]   = rd_in;
      end
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
      sdt_grp u_grp (
         .clock      (clock),
         .hit_first  (hit_first[g*GRP_SIZE +: GRP_SIZE]),
         .free_first (free_first[g*GRP_SIZE +: GRP_SIZE]),
         .rd_chain   (rd_chain[g*GRP_SIZE + GRP_SIZE - 1]),
         .grp        (grp[g])
      );
   end

   // lowest group wins
   always_comb begin
      hit_any   = 1'b0;
      free_any  = 1'b0;
      hit_slot  = '0;
      free_slot = '0;
      rd_all    = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (!hit_any && grp[g].any_hit) begin
            hit_any  = 1'b1;
            hit_slot = SLOT_W'(g * GRP_SIZE + int'(grp[g].hit_idx));
         end
         if (!free_any && grp[g].any_free) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(g * GRP_SIZE + int'(grp[g].free_idx));
         end
         rd_all = sdt_entry_type'(rd_all | grp[g].rd);
      end
   end

   always_comb begin
      bind_ok    = 1'b0;
      close_ok   = 1'b0;
      res_status = ST_OK;
      res_slot   = '0;
      res_icmp   = 1'b0;
      res_ip     = '0;
      res_lport  = '0;
      res_rport  = '0;
      res_kind   = '0;
      res_sub    = '0;
      unique case (cmd_ff)
         CMD_BIND_UDP, CMD_BIND_ICMP: begin
            if (hit_any) begin
               res_status = ST_DUP;
               res_slot   = SLOT_IO_W'(hit_slot);
            end else if (free_any) begin
               bind_ok  = 1'b1;
               res_slot = SLOT_IO_W'(free_slot);
            end else begin
               res_status = ST_FULL;
            end
         end
         CMD_CLOSE: begin
            res_slot = slot_ff;
            if (rd_all.valid) begin
               close_ok = 1'b1;
            end else begin
               res_status = ST_EMPTY;
            end
         end
         CMD_DELIVER_UDP, CMD_DELIVER_ICMP: begin
            if (hit_any) begin
               res_slot = SLOT_IO_W'(hit_slot);
            end else begin
               res_status = ST_DROP;
            end
         end
         CMD_DESCRIBE: begin
            res_slot = slot_ff;
            if (rd_all.valid) begin
               res_icmp = rd_all.icmp;
               res_ip   = rd_all.addr;
               if (rd_all.icmp) begin
                  res_kind = rd_all.ports[15:8];
                  res_sub  = rd_all.ports[7:0];
               end else begin
                  res_lport = rd_all.ports[31:16];
                  res_rport = rd_all.ports[15:0];
               end
            end else begin
               res_status = ST_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sel_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_fire) begin
         rsp_user_ff <= {res_icmp, res_status};
         rsp_data_ff <= {2'd0, res_sub, res_kind, res_rport, res_lport, res_ip, res_slot};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SDT_ASSERT_NOW(a_one_write, clock, reset, 1'b1, $onehot0(cell_set | cell_clr), "more than one cell written")
   `SDT_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == S_CMP && !req_tready, "accept did not start compare")
   `SDT_ASSERT_NOW(a_write_needs_room, clock, reset, (|cell_set) || (|cell_clr), !rsp_valid_ff || rsp_tready, "table written while result stalled")
   `SDT_ASSERT_NEXT(a_result_loaded, clock, reset, sel_fire, rsp_tvalid && state_ff == S_IDLE, "select did not load result")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// socket demux table testbench
// drives bind, close, deliver and describe commands into the socket table,
// tracks the bound sockets in a local copy of the table, and checks every
// response field against the value that copy predicts
// ----------------------------------------------------------------------------
module tb_top;
   import sdt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [IP_W-1:0]      remote_ip;
      logic [PORT_W-1:0]    local_port;
      logic [PORT_W-1:0]    remote_port;
      logic [ICMP_W-1:0]    icmp_kind;
      logic [ICMP_W-1:0]    icmp_subcode;
      logic [SLOT_IO_W-1:0] slot_in;
   } sock_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_IO_W-1:0] slot;
      logic                 is_icmp;
      logic [IP_W-1:0]      remote_ip;
      logic [PORT_W-1:0]    local_port;
      logic [PORT_W-1:0]    remote_port;
      logic [ICMP_W-1:0]    icmp_kind;
      logic [ICMP_W-1:0]    icmp_subcode;
   } sock_rsp_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // local copy of the socket table
   bit                    tbl_valid [TABLE_SLOTS];
   bit                    tbl_icmp  [TABLE_SLOTS];
   bit [31:0]             tbl_addr  [TABLE_SLOTS];
   bit [31:0]             tbl_ports [TABLE_SLOTS];

   sock_rsp_type          pending_results [$];
   int                    mismatch_count = 0;
   bit                    src_idle_on    = 1'b1;
   bit                    sink_idle_on   = 1'b1;
   int                    rsp_hold_cycles = 0;
   logic [IP_W-1:0]       ip_pool   [8];
   logic [PORT_W-1:0]     port_pool [4];

   socket_demux_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[socket_demux_table] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int find_socket(input logic icmp, input logic [31:0] ip,
                                      input logic [31:0] ports);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (tbl_valid[i] && tbl_icmp[i] == icmp && tbl_addr[i] == ip &&
             (icmp || tbl_ports[i] == ports))
            return i;
      end
      return -1;
   endfunction

   function automatic sock_rsp_type predict_socket_op(input sock_req_type r);
      sock_rsp_type res;
      logic [31:0]  udp_ports;
      logic         slot_live;
      int           hit;
      int           free_slot;
      res       = '0;
      udp_ports = {r.local_port, r.remote_port};
      slot_live = (int'(r.slot_in) < TABLE_SLOTS) && tbl_valid[r.slot_in];
      case (r.cmd)
         CMD_BIND_UDP, CMD_BIND_ICMP: begin
            hit = find_socket(r.cmd == CMD_BIND_ICMP, r.remote_ip, udp_ports);
            if (hit >= 0) begin
               res.status = ST_DUP;
               res.slot   = SLOT_IO_W'(hit);
            end else begin
               free_slot = -1;
               for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                  if (!tbl_valid[i]) free_slot = i;
               if (free_slot < 0) begin
                  res.status = ST_FULL;
               end else begin
                  tbl_valid[free_slot] = 1'b1;
                  tbl_icmp[free_slot]  = (r.cmd == CMD_BIND_ICMP);
                  tbl_addr[free_slot]  = r.remote_ip;
                  tbl_ports[free_slot] = (r.cmd == CMD_BIND_ICMP) ?
                                         {16'h0000, r.icmp_kind, r.icmp_subcode} : udp_ports;
                  res.status = ST_OK;
                  res.slot   = SLOT_IO_W'(free_slot);
               end
            end
         end
         CMD_CLOSE: begin
            res.slot = r.slot_in;
            if (slot_live) begin
               tbl_valid[r.slot_in] = 1'b0;
               res.status = ST_OK;
            end else begin
               res.status = ST_EMPTY;
            end
         end
         CMD_DELIVER_UDP, CMD_DELIVER_ICMP: begin
            hit = find_socket(r.cmd == CMD_DELIVER_ICMP, r.remote_ip, udp_ports);
            if (hit < 0) begin
               res.status = ST_DROP;
            end else begin
               res.status = ST_OK;
               res.slot   = SLOT_IO_W'(hit);
            end
         end
         CMD_DESCRIBE: begin
            res.slot = r.slot_in;
            if (slot_live) begin
               res.status    = ST_OK;
               res.is_icmp   = tbl_icmp[r.slot_in];
               res.remote_ip = tbl_addr[r.slot_in];
               if (tbl_icmp[r.slot_in]) begin
                  res.icmp_kind    = tbl_ports[r.slot_in][15:8];
                  res.icmp_subcode = tbl_ports[r.slot_in][7:0];
               end else begin
                  res.local_port  = tbl_ports[r.slot_in][31:16];
                  res.remote_port = tbl_ports[r.slot_in][15:0];
               end
            end else begin
               res.status = ST_EMPTY;
            end
         end
         default: begin
            // reserved commands answer ok with everything zero
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      sock_rsp_type got;
      sock_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tuser[2:0];
         got.is_icmp      = rsp_tuser[3];
         got.slot         = rsp_tdata[5:0];
         got.remote_ip    = rsp_tdata[37:6];
         got.local_port   = rsp_tdata[53:38];
         got.remote_port  = rsp_tdata[69:54];
         got.icmp_kind    = rsp_tdata[77:70];
         got.icmp_subcode = rsp_tdata[85:78];
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, status", got.status, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.slot !== want.slot)
               report_mismatch("slot_out", got.slot, want.slot);
            if (got.is_icmp !== want.is_icmp)
               report_mismatch("is_icmp", got.is_icmp, want.is_icmp);
            if (got.remote_ip !== want.remote_ip)
               report_mismatch("out_remote_ip", got.remote_ip, want.remote_ip);
            if (got.local_port !== want.local_port)
               report_mismatch("out_local_port", got.local_port, want.local_port);
            if (got.remote_port !== want.remote_port)
               report_mismatch("out_remote_port", got.remote_port, want.remote_port);
            if (got.icmp_kind !== want.icmp_kind)
               report_mismatch("out_icmp_kind", got.icmp_kind, want.icmp_kind);
            if (got.icmp_subcode !== want.icmp_subcode)
               report_mismatch("out_icmp_subcode", got.icmp_subcode, want.icmp_subcode);
         end
      end
   end

   // result side: random stall bursts, plus a long hold when a test asks for one
   initial begin : rsp_sink
      int stall;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic sock_req_type socket_req(input logic [CMD_W-1:0] cmd,
                                               input logic [31:0] ip,
                                               input logic [15:0] lport,
                                               input logic [15:0] rport,
                                               input logic [7:0] kind,
                                               input logic [7:0] sub,
                                               input logic [5:0] slot);
      sock_req_type r;
      r.cmd          = cmd;
      r.remote_ip    = ip;
      r.local_port   = lport;
      r.remote_port  = rport;
      r.icmp_kind    = kind;
      r.icmp_subcode = sub;
      r.slot_in      = slot;
      return r;
   endfunction

   task automatic send_item(input sock_req_type r);
      int gap;
      if (src_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {2'b00, r.slot_in, r.icmp_subcode, r.icmp_kind, r.remote_port,
                     r.local_port, r.remote_ip};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_socket_op(r));
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [5:0] pick_bound_slot();
      int start;
      start = $urandom_range(0, TABLE_SLOTS - 1);
      for (int k = 0; k < TABLE_SLOTS; k++)
         if (tbl_valid[(start + k) % TABLE_SLOTS]) return 6'((start + k) % TABLE_SLOTS);
      return 6'(start);
   endfunction

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 4) == 0) return $urandom();
      return ip_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [15:0] pick_port();
      if ($urandom_range(0, 4) == 0) return 16'($urandom());
      return port_pool[$urandom_range(0, 3)];
   endfunction

   // mostly well-formed traffic on a small key space so that duplicates, hits
   // and a full table all turn up; six in a hundred are noise with every field random
   task automatic gen_socket_req(output sock_req_type r);
      int roll;
      int s;
      r = socket_req(CMD_BIND_UDP, pick_ip(), pick_port(), pick_port(),
                     8'($urandom()), 8'($urandom()), 6'($urandom()));
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
         r.cmd = CMD_BIND_UDP;
      end else if (roll < 34) begin
         r.cmd = CMD_BIND_ICMP;
      end else if (roll < 56) begin
         r.cmd = CMD_CLOSE;
         if ($urandom_range(0, 3) != 0) r.slot_in = pick_bound_slot();
      end else if (roll < 82) begin
         r.cmd = (roll < 72) ? CMD_DELIVER_UDP : CMD_DELIVER_ICMP;
         s = pick_bound_slot();
         if (tbl_valid[s] && $urandom_range(0, 3) != 0) begin
            r.remote_ip = tbl_addr[s];
            if (!tbl_icmp[s]) {r.local_port, r.remote_port} = tbl_ports[s];
         end
      end else if (roll < 94) begin
         r.cmd = CMD_DESCRIBE;
         if ($urandom_range(0, 3) != 0) r.slot_in = pick_bound_slot();
      end else begin
         r = socket_req(3'($urandom()), $urandom(), 16'($urandom()), 16'($urandom()),
                        8'($urandom()), 8'($urandom()), 6'($urandom()));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // empty table: describe, close and both delivers miss
      send_item(socket_req(CMD_DESCRIBE, '0, '0, '0, '0, '0, 6'd0));
      send_item(socket_req(CMD_CLOSE, '1, '1, '1, '1, '1, 6'd63));
      send_item(socket_req(CMD_DELIVER_UDP, '0, '0, '0, '0, '0, '0));
      send_item(socket_req(CMD_DELIVER_ICMP, '1, '1, '1, '1, '1, '1));
      // extremes of the key fields
      send_item(socket_req(CMD_BIND_UDP, '0, '0, '0, '0, '0, '0));
      send_item(socket_req(CMD_BIND_UDP, '1, '1, '1, '1, '1, '1));
      send_item(socket_req(CMD_BIND_UDP, '0, '0, '0, '1, '1, '1));
      // icmp on an address a udp socket holds is no duplicate
      send_item(socket_req(CMD_BIND_ICMP, '0, '1, '1, 8'hff, 8'hff, '0));
      // second icmp on that address clashes whatever its type and code
      send_item(socket_req(CMD_BIND_ICMP, '0, '0, '0, 8'h00, 8'h00, '0));
      send_item(socket_req(CMD_BIND_UDP, '1, '1, '0, '0, '0, '0));
      send_item(socket_req(CMD_DELIVER_UDP, '0, '0, '0, '0, '0, '0));
      send_item(socket_req(CMD_DELIVER_ICMP, '0, '1, '1, '0, '0, '0));
      send_item(socket_req(CMD_DELIVER_UDP, '1, '0, '1, '0, '0, '0));
      send_item(socket_req(CMD_DELIVER_ICMP, '1, '0, '0, '0, '0, '0));
      send_item(socket_req(CMD_DESCRIBE, '0, '0, '0, '0, '0, 6'd1));
      send_item(socket_req(CMD_DESCRIBE, '1, '1, '1, '1, '1, 6'd2));
      // free slot 0, then the next bind takes the lowest free slot again
      send_item(socket_req(CMD_CLOSE, '0, '0, '0, '0, '0, 6'd0));
      send_item(socket_req(CMD_DESCRIBE, '0, '0, '0, '0, '0, 6'd0));
      send_item(socket_req(CMD_CLOSE, '0, '0, '0, '0, '0, 6'd0));
      send_item(socket_req(CMD_BIND_UDP, 32'h0a000001, 16'h1234, 16'h0035, '0, '0, '0));
      send_item(socket_req(CMD_DESCRIBE, '0, '0, '0, '0, '0, 6'd0));
      send_item(socket_req(CMD_RSVD_A, '1, '1, '1, '1, '1, '1));
      send_item(socket_req(CMD_RSVD_B, '1, '1, '1, '1, '1, 6'd3));
      wait_all_results();
   endtask

   task automatic test_full_table();
      sock_req_type r;
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         r = socket_req($urandom_range(0, 1) ? CMD_BIND_ICMP : CMD_BIND_UDP, $urandom(),
                        16'($urandom()), 16'($urandom()), 8'($urandom()), 8'($urandom()),
                        6'($urandom()));
         send_item(r);
      end
      send_item(socket_req(CMD_BIND_UDP, 32'h7f000001, 16'h0007, 16'h0007, '0, '0, '0));
      send_item(socket_req(CMD_BIND_ICMP, 32'h7f000002, '0, '0, 8'h08, 8'h00, '0));
      // duplicate check comes before the full check
      r = socket_req(tbl_icmp[5] ? CMD_BIND_ICMP : CMD_BIND_UDP, tbl_addr[5],
                     tbl_ports[5][31:16], tbl_ports[5][15:0], '0, '0, '0);
      send_item(r);
      r = socket_req(tbl_icmp[63] ? CMD_DELIVER_ICMP : CMD_DELIVER_UDP, tbl_addr[63],
                     tbl_ports[63][31:16], tbl_ports[63][15:0], '0, '0, '0);
      send_item(r);
      send_item(socket_req(CMD_DESCRIBE, '0, '0, '0, '0, '0, 6'd63));
      for (int k = 0; k < TABLE_SLOTS; k++)
         send_item(socket_req(CMD_CLOSE, $urandom(), '0, '0, '0, '0, 6'(k)));
      wait_all_results();
   endtask

   // hold the result side so the pipeline backs up into the request side
   task automatic test_output_stall();
      sock_req_type r;
      src_idle_on     = 1'b0;
      rsp_hold_cycles = 150;
      for (int k = 0; k < 40; k++) begin
         gen_socket_req(r);
         send_item(r);
      end
      wait_all_results();
   endtask

   task automatic test_random_traffic();
      sock_req_type r;
      for (int k = 0; k < 1100; k++) begin
         // idling comes and goes in stretches
         if (k % 100 == 0) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
         end
         gen_socket_req(r);
         send_item(r);
      end
   endtask

   task automatic test_unpaced_finish();
      sock_req_type r;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      for (int k = 0; k < 150; k++) begin
         gen_socket_req(r);
         send_item(r);
      end
   endtask

   initial begin
      // small key pools shared by every test that draws its traffic from gen_socket_req
      ip_pool[0]   = '0;
      ip_pool[1]   = '1;
      port_pool[0] = '0;
      port_pool[1] = '1;
      for (int k = 2; k < 8; k++) ip_pool[k] = $urandom();
      for (int k = 2; k < 4; k++) port_pool[k] = 16'($urandom());
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_output_stall();
      test_random_traffic();
      test_unpaced_finish();
      wait_all_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[socket_demux_table] OK");
      else
         $display("[socket_demux_table] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sdt_pkg.sv
hdl/sdt_cell.sv
hdl/sdt_grp.sv
hdl/socket_demux_table.sv
test/tb_top.sv
